// ===== rtl/tscs_pkg.sv =====
package tscs_pkg;

    // Operation carried in the input item's tuser.
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_BEGIN  = 2'd1,
        OP_REPORT = 2'd2
    } op_t;

    // Configuration register indexes (byte address bit 2).
    localparam logic [0:0] REG_VARIANCE_LIMIT = 1'b0;
    localparam logic [0:0] REG_STABLE_TICKS   = 1'b1;

    // Register reset values.
    localparam int unsigned LIMIT_RESET = 1600;
    localparam logic [7:0]  TICKS_RESET = 8'd20;

    // Number of poses; a step equal to this means all poses are captured.
    localparam logic [2:0] POSE_COUNT = 3'd5;

    // Longest stable run that is counted.
    localparam logic [7:0] RUN_MAX = 8'hFF;

    // One result item, first field in the highest bits.
    typedef struct packed {
        logic       stable;
        logic       error;
        logic       done_res;
        logic       capture_request;
        logic [2:0] step;
    } result_t;

endpackage

// ===== rtl/tilt_stillness_calibration_sequencer_unit.sv =====
// Channel   | Direction | Payload
// ----------+-----------+---------------------------------------------------------
// s_        | in        | tuser: op; tdata: sample_x, sample_y, capture_ok
// m_        | out       | tdata: step, capture_request, done_res, error, stable
// APB       | in/out    | variance_limit at 0x0, stable_ticks at 0x4
//
// One item is taken every clock cycle while m_tready is high; each item is accepted into the
// input register, and its result is then loaded from there into the result register.
// Each sample updates running sums and an incremental variance term with one product of
// two variables per axis, so the whole update fits between the two registers.
// Reset is synchronous on aresetn and needs no clearing pass; ring entries are
// only read back once the window has been filled again.
// When m_tready is low the result register holds, the input register fills behind
// it and s_tready then falls until the result is taken.
module tilt_stillness_calibration_sequencer_unit
    import tscs_pkg::*;
#(
    parameter int WINDOW = 20
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [15:0] sample_x, [31:16] sample_y, [32] capture_ok
    input  logic [1:0]  s_tuser,   // [1:0] op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] step, [3] capture_request, [4] done_res,
                                   // [5] error, [6] stable

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LOGW  = $clog2(WINDOW + 1);
    localparam int WP_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = 16 + LOGW;
    localparam int T_W   = LOGW + 19;
    localparam int P_W   = T_W + 17;
    localparam int V_W   = 2 * LOGW + 32;
    localparam int RHS_W = 31 + 2 * LOGW;
    localparam int WSQ   = WINDOW * WINDOW;

    localparam logic [WP_W-1:0]       WP_LAST   = WP_W'(WINDOW - 1);
    localparam logic [LOGW-1:0]       FILL_FULL = LOGW'(WINDOW);
    localparam logic signed [T_W-1:0] W_T       = T_W'(WINDOW);
    localparam logic [RHS_W-1:0]      RHS_RESET = RHS_W'(LIMIT_RESET) * RHS_W'(WSQ);

    // Input register.
    logic               in_valid_reg, in_valid_next;
    op_t                in_op_reg;
    logic signed [15:0] in_x_reg, in_y_reg;
    logic               in_ok_reg;

    // Result register.
    logic    m_valid_reg, m_valid_next;
    result_t res_reg, res_next;

    // Window and sequencing state.
    logic [WP_W-1:0]         wp_reg, wp_next;
    logic [LOGW-1:0]         fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic signed [V_W-1:0]   v_x_reg, v_x_next, v_y_reg, v_y_next;
    logic [7:0]              run_reg, run_next;
    logic [2:0]              step_reg, step_next;
    logic                    await_reg, await_next;
    logic                    err_reg, err_next;

    // Configuration.
    logic [30:0]      limit_reg;
    logic [7:0]       ticks_reg;
    logic [RHS_W-1:0] rhs_reg;
    logic             cfg_we;

    // Sample rings and the prefetched entry that the next sample replaces.
    logic signed [15:0] ring_x [WINDOW];
    logic signed [15:0] ring_y [WINDOW];
    logic signed [15:0] old_x_reg, old_y_reg;
    logic               ring_we;

    // Datapath temporaries.
    logic                    s_accept, fire, sample_ok, full_now, full_upd;
    logic                    still_x, still_y, still, request;
    logic signed [15:0]      ox, oy;
    logic signed [SUM_W-1:0] sx_upd, sy_upd;
    logic signed [V_W-1:0]   vx_upd, vy_upd, rhs_ext;
    logic [LOGW-1:0]         fill_upd;
    logic [WP_W-1:0]         wp_upd;
    logic [7:0]              run_inc;

    // Running update of one axis. v holds WINDOW*sumsq - sum*sum, and replacing
    // entry o by x with d = x - o changes it by d*(WINDOW*(x + o) - 2*sum - d).
    function automatic void axis_step(
        input  logic signed [15:0]      x,
        input  logic signed [15:0]      o,
        input  logic signed [SUM_W-1:0] s,
        input  logic signed [V_W-1:0]   v,
        output logic signed [SUM_W-1:0] s_new,
        output logic signed [V_W-1:0]   v_new
    );
        logic signed [16:0]    d;
        logic signed [16:0]    xo;
        logic signed [T_W-1:0] wxo;
        logic signed [T_W-1:0] t;
        logic signed [P_W-1:0] prod;
        d     = 17'(x) - 17'(o);
        xo    = 17'(x) + 17'(o);
        wxo   = T_W'(xo) * W_T;
        t     = wxo - (T_W'(s) <<< 1) - T_W'(d);
        prod  = P_W'(d) * P_W'(t);
        s_new = s + SUM_W'(d);
        v_new = v + V_W'(prod);
    endfunction

    // Handshakes: the input register moves on when the result register is free.
    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_reg};

    always_comb begin
        in_valid_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        m_valid_next  = fire ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // Sample datapath, evaluated for the item in the input register.
    always_comb begin
        full_now = (fill_reg == FILL_FULL);
        ox       = full_now ? old_x_reg : '0;
        oy       = full_now ? old_y_reg : '0;
        axis_step(in_x_reg, ox, sum_x_reg, v_x_reg, sx_upd, vx_upd);
        axis_step(in_y_reg, oy, sum_y_reg, v_y_reg, sy_upd, vy_upd);
        fill_upd = full_now ? fill_reg : fill_reg + 1'b1;
        full_upd = (fill_upd == FILL_FULL);
        rhs_ext  = $signed({1'b0, rhs_reg});
        still_x  = full_upd && (vx_upd < rhs_ext);
        still_y  = full_upd && (vy_upd < rhs_ext);
        wp_upd   = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
        run_inc  = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
        sample_ok = !err_reg && (step_reg < POSE_COUNT) && !await_reg;
        if (step_reg == '0) begin
            still = still_x && still_y;
        end else if (step_reg inside {[3'd1:3'd2]}) begin
            still = still_x;
        end else begin
            still = still_y;
        end
    end

    // Next state for the item being executed.
    always_comb begin
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        v_x_next   = v_x_reg;
        v_y_next   = v_y_reg;
        run_next   = run_reg;
        step_next  = step_reg;
        await_next = await_reg;
        err_next   = err_reg;
        ring_we    = 1'b0;
        request    = 1'b0;
        res_next   = res_reg;
        if (fire) begin
            case (in_op_reg)
                OP_SAMPLE: begin
                    if (sample_ok) begin
                        ring_we    = 1'b1;
                        wp_next    = wp_upd;
                        fill_next  = fill_upd;
                        sum_x_next = sx_upd;
                        sum_y_next = sy_upd;
                        v_x_next   = vx_upd;
                        v_y_next   = vy_upd;
                        run_next   = still ? run_inc : '0;
                        request    = still && (run_inc >= ticks_reg);
                        if (request) begin
                            await_next = 1'b1;
                        end
                    end
                end
                OP_BEGIN: begin
                    wp_next    = '0;
                    fill_next  = '0;
                    sum_x_next = '0;
                    sum_y_next = '0;
                    v_x_next   = '0;
                    v_y_next   = '0;
                    run_next   = '0;
                    step_next  = '0;
                    await_next = 1'b0;
                    err_next   = 1'b0;
                end
                OP_REPORT: begin
                    if (await_reg) begin
                        await_next = 1'b0;
                        if (in_ok_reg) begin
                            if (step_reg < POSE_COUNT) begin
                                step_next = step_reg + 1'b1;
                            end
                            wp_next    = '0;
                            fill_next  = '0;
                            sum_x_next = '0;
                            sum_y_next = '0;
                            v_x_next   = '0;
                            v_y_next   = '0;
                            run_next   = '0;
                        end else begin
                            err_next = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            res_next.step            = step_next;
            res_next.capture_request = request;
            res_next.done_res        = (step_next >= POSE_COUNT);
            res_next.error           = err_next;
            res_next.stable          = (in_op_reg == OP_SAMPLE) && sample_ok && still;
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            v_x_reg      <= '0;
            v_y_reg      <= '0;
            run_reg      <= '0;
            step_reg     <= '0;
            await_reg    <= 1'b0;
            err_reg      <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            v_x_reg      <= v_x_next;
            v_y_reg      <= v_y_next;
            run_reg      <= run_next;
            step_reg     <= step_next;
            await_reg    <= await_next;
            err_reg      <= err_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg <= op_t'(s_tuser);
            in_x_reg  <= $signed(s_tdata[15:0]);
            in_y_reg  <= $signed(s_tdata[31:16]);
            in_ok_reg <= s_tdata[32];
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    // Rings: write the new sample, prefetch the entry at the next write position.
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_x[wp_reg] <= in_x_reg;
            ring_y[wp_reg] <= in_y_reg;
        end
        old_x_reg <= ring_x[wp_next];
        old_y_reg <= ring_y[wp_next];
    end

    // Configuration port; the variance bound is kept pre-scaled by WINDOW squared.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 31'(LIMIT_RESET);
            rhs_reg   <= RHS_RESET;
            ticks_reg <= TICKS_RESET;
        end else if (cfg_we) begin
            case (paddr[2:2])
                REG_VARIANCE_LIMIT: begin
                    limit_reg <= pwdata[30:0];
                    rhs_reg   <= RHS_W'(pwdata[30:0]) * RHS_W'(WSQ);
                end
                REG_STABLE_TICKS: begin
                    ticks_reg <= pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2:2])
            REG_VARIANCE_LIMIT: prdata = {1'b0, limit_reg};
            REG_STABLE_TICKS:   prdata = {24'd0, ticks_reg};
            default:            prdata = '0;
        endcase
    end

    // The window never overfills and the write position stays inside the ring.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("window fill count beyond its depth");

    a_wp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= WP_LAST)
        else $error("write position outside the ring");

    // A capture request always leaves a report pending.
    a_request_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_next.capture_request |=> await_reg)
        else $error("capture requested without a pending report");

    // No sample is judged stable while a report is awaited.
    a_halted_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && await_reg && (in_op_reg == OP_SAMPLE) |-> !res_next.stable)
        else $error("sample judged while a report is awaited");

endmodule

// ===== sim/testbench.sv =====
module testbench
    import tscs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_LEN = 20;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned LIMIT_TOP = 32'h4000_0000;
    localparam int IDLE_PCT = 29;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [15:0] sample_x, [31:16] sample_y, [32] capture_ok
    logic [1:0]  s_tuser;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [2:0] step, [3] capture_request, [4] done_res,
                            // [5] error, [6] stable
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tilt_stillness_calibration_sequencer_unit #(.WINDOW(WIN_LEN)) dut (.*);

    // Predicted state of the sequencer and its register copies.
    logic signed [15:0] win_x [WIN_LEN];
    logic signed [15:0] win_y [WIN_LEN];
    int          win_pos;
    int          win_fill;
    longint      acc_x, acc_y, acc_sq_x, acc_sq_y;
    int          still_run;
    logic [2:0]  cur_step;
    bit          capture_pending;
    bit          fault_latched;
    longint      cfg_limit;
    int          cfg_ticks;

    result_t     expected_status [$];
    int          fail_count;
    bit          tx_gaps_on;
    bit          rx_gaps_on;
    int          rx_hold_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // A hard stop in case the block locks up.
    initial begin
        #5_000_000;
        $display("[tilt_stillness_calibration_sequencer_unit] ERROR");
        $finish;
    end

    function automatic void clear_window();
        for (int i = 0; i < WIN_LEN; i++) begin
            win_x[i] = '0;
            win_y[i] = '0;
        end
        win_pos = 0;
        win_fill = 0;
        acc_x = 0;
        acc_y = 0;
        acc_sq_x = 0;
        acc_sq_y = 0;
        still_run = 0;
    endfunction

    // Exact variance test: N*sum_sq - sum^2 < N^2*limit, only on a full window.
    function automatic bit axis_is_still(longint total, longint total_sq);
        longint mag;
        longint unsigned lhs, rhs;
        if (win_fill < WIN_LEN)
            return 1'b0;
        mag = (total < 0) ? -total : total;
        lhs = longint'(WIN_LEN) * total_sq - mag * mag;
        rhs = longint'(WIN_LEN) * longint'(WIN_LEN) * cfg_limit;
        return lhs < rhs;
    endfunction

    // Advances the predicted state by one accepted item and returns its status.
    function automatic result_t predict_status(logic [1:0] op, logic signed [15:0] sx,
                                               logic signed [15:0] sy, logic ok);
        result_t r;
        bit request, still;
        logic signed [15:0] ox, oy;
        request = 1'b0;
        still = 1'b0;
        case (op)
            OP_SAMPLE: begin
                if (!fault_latched && cur_step < POSE_COUNT && !capture_pending) begin
                    if (win_fill >= WIN_LEN) begin
                        ox = win_x[win_pos];
                        oy = win_y[win_pos];
                        acc_x -= longint'(ox);
                        acc_y -= longint'(oy);
                        acc_sq_x -= longint'(ox) * longint'(ox);
                        acc_sq_y -= longint'(oy) * longint'(oy);
                    end
                    win_x[win_pos] = sx;
                    win_y[win_pos] = sy;
                    acc_x += longint'(sx);
                    acc_y += longint'(sy);
                    acc_sq_x += longint'(sx) * longint'(sx);
                    acc_sq_y += longint'(sy) * longint'(sy);
                    win_pos = (win_pos + 1) % WIN_LEN;
                    if (win_fill < WIN_LEN)
                        win_fill++;
                    if (cur_step == 3'd0)
                        still = axis_is_still(acc_x, acc_sq_x) && axis_is_still(acc_y, acc_sq_y);
                    else if (cur_step <= 3'd2)
                        still = axis_is_still(acc_x, acc_sq_x);
                    else
                        still = axis_is_still(acc_y, acc_sq_y);
                    if (still) begin
                        if (still_run < int'(RUN_MAX))
                            still_run++;
                        if (still_run >= cfg_ticks) begin
                            request = 1'b1;
                            capture_pending = 1'b1;
                        end
                    end else begin
                        still_run = 0;
                    end
                end
            end
            OP_BEGIN: begin
                clear_window();
                cur_step = 3'd0;
                capture_pending = 1'b0;
                fault_latched = 1'b0;
            end
            OP_REPORT: begin
                if (capture_pending) begin
                    capture_pending = 1'b0;
                    if (ok) begin
                        if (cur_step < POSE_COUNT)
                            cur_step++;
                        clear_window();
                    end else begin
                        fault_latched = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.step = cur_step;
        r.capture_request = request;
        r.done_res = (cur_step >= POSE_COUNT);
        r.error = fault_latched;
        r.stable = still;
        return r;
    endfunction

    task automatic note_mismatch(string what, longint want, longint got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s: expected %0d, got %0d", what, want, got);
    endtask

    // Sends one item with random gaps before it; valid is lowered only while idling.
    task automatic send_item(logic [1:0] op, logic [15:0] sx, logic [15:0] sy, logic ok);
        @(negedge aclk);
        while (tx_gaps_on && $urandom_range(99, 0) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'b0, ok, sy, sx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_status.push_back(predict_status(op, sx, sy, ok));
    endtask

    task automatic send_begin();
        send_item(OP_BEGIN, 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic send_report(logic ok);
        send_item(OP_REPORT, 16'($urandom), 16'($urandom), ok);
    endtask

    function automatic logic [15:0] near_value(int centre, int spread);
        int v;
        v = centre + int'($urandom_range(2 * spread, 0)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task automatic send_samples(int n, int cx, int spread_x, int cy, int spread_y);
        for (int i = 0; i < n; i++)
            send_item(OP_SAMPLE, near_value(cx, spread_x), near_value(cy, spread_y),
                      1'($urandom));
    endtask

    // Holds the axes that the current pose tests still, shakes the others, then reports.
    task automatic run_pose(int n, logic ok);
        int spread_x, spread_y;
        spread_x = (cur_step <= 3'd2) ? 2 : 32767;
        spread_y = (cur_step == 3'd0 || cur_step >= 3'd3) ? 2 : 32767;
        send_samples(n, (spread_x == 2) ? 1200 : 0, spread_x,
                     (spread_y == 2) ? -800 : 0, spread_y);
        send_report(ok);
    endtask

    // Stops offering items and lets every expected result drain out.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [0:0] idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes a register, reads it back and mirrors it in the prediction.
    task automatic set_config(logic [0:0] idx, int unsigned value);
        logic [31:0] rd;
        logic [31:0] want;
        want = (idx == REG_VARIANCE_LIMIT) ? (value & 32'h7FFF_FFFF) : (value & 32'hFF);
        apb_access(1'b1, idx, value, rd);
        apb_access(1'b0, idx, '0, rd);
        if (rd !== want)
            note_mismatch("register read-back", want, rd);
        if (idx == REG_VARIANCE_LIMIT)
            cfg_limit = want;
        else
            cfg_ticks = want;
    endtask

    task automatic test_register_access();
        logic [31:0] rd;
        apb_access(1'b0, REG_VARIANCE_LIMIT, '0, rd);
        if (rd !== LIMIT_RESET)
            note_mismatch("variance_limit reset value", LIMIT_RESET, rd);
        apb_access(1'b0, REG_STABLE_TICKS, '0, rd);
        if (rd !== 32'(TICKS_RESET))
            note_mismatch("stable_ticks reset value", TICKS_RESET, rd);
        set_config(REG_VARIANCE_LIMIT, 0);
        set_config(REG_VARIANCE_LIMIT, LIMIT_TOP);
        set_config(REG_VARIANCE_LIMIT, LIMIT_RESET);
        set_config(REG_STABLE_TICKS, 1);
        set_config(REG_STABLE_TICKS, 255);
        set_config(REG_STABLE_TICKS, TICKS_RESET);
    endtask

    // Field extremes, the unused operation and reports that nobody asked for.
    task automatic test_field_extremes();
        send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
        send_report(1'b1);
        send_report(1'b0);
        send_begin();
        send_item(OP_SAMPLE, 16'h7FFF, 16'h8000, 1'b0);
        send_item(OP_SAMPLE, 16'h8000, 16'h7FFF, 1'b1);
        send_item(OP_SAMPLE, 16'h0000, 16'h0000, 1'b0);
        send_item(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(OP_SAMPLE, 16'h5555, 16'hAAAA, 1'b0);
        send_item(OP_SAMPLE, 16'hAAAA, 16'h5555, 1'b1);
        send_item(OP_SAMPLE, 16'h0001, 16'hFFFE, 1'b0);
        send_item(OP_UNUSED, 16'h0000, 16'h0000, 1'b0);
        send_begin();
    endtask

    // Capture handshake: request on the first stable tick, samples ignored while a
    // report is awaited, failed capture halting, and the run through all poses.
    task automatic test_capture_flow();
        wait_idle();
        set_config(REG_STABLE_TICKS, 0);
        send_begin();
        send_samples(20, 500, 0, -500, 0);
        send_samples(1, 500, 0, -500, 0);
        send_report(1'b1);
        run_pose(20, 1'b0);
        send_samples(2, 0, 100, 0, 100);
        send_report(1'b1);
        send_item(OP_UNUSED, 16'h1234, 16'h4321, 1'b1);
        send_begin();
        wait_idle();
        set_config(REG_STABLE_TICKS, 1);
        for (int p = 0; p < 5; p++)
            run_pose(21, 1'b1);
        send_samples(2, 0, 5, 0, 5);
        send_report(1'b1);
        send_begin();
    endtask

    // Longest stable run with the widest limit: full-range samples still pass.
    task automatic test_slow_ticks();
        wait_idle();
        set_config(REG_VARIANCE_LIMIT, LIMIT_TOP);
        set_config(REG_STABLE_TICKS, 255);
        send_begin();
        send_samples(275, 0, 32767, 0, 32767);
        send_report(1'b1);
    endtask

    // Mostly well-formed calibration runs with random content, some noise between.
    task automatic test_random_calibration();
        int useful;
        int cx, cy, spread_x, spread_y;
        logic [2:0] seen_step;
        logic [1:0] op;
        int unsigned pick;
        for (int phase = 0; phase < 2; phase++) begin
            wait_idle();
            pick = $urandom_range(3, 0);
            set_config(REG_VARIANCE_LIMIT, (pick == 0) ? 0 : (pick == 1) ? LIMIT_RESET :
                       (pick == 2) ? $urandom_range(4000, 1) : LIMIT_TOP);
            set_config(REG_STABLE_TICKS, ($urandom_range(4, 0) == 0) ? 20 : $urandom_range(6, 1));
            seen_step = 3'd7;
            useful = 0;
            while (useful < 50) begin
                if (cur_step != seen_step) begin
                    seen_step = cur_step;
                    cx = int'($urandom_range(60000, 0)) - 30000;
                    cy = int'($urandom_range(60000, 0)) - 30000;
                    pick = $urandom_range(5, 0);
                    spread_x = (pick == 5) ? 300 : (1 << (2 * pick)) >> 2;
                    pick = $urandom_range(5, 0);
                    spread_y = (pick == 5) ? 300 : (1 << (2 * pick)) >> 2;
                    if (cur_step == 3'd1 || cur_step == 3'd2)
                        spread_y = $urandom_range(20000, 0);
                    else if (cur_step >= 3'd3)
                        spread_x = $urandom_range(20000, 0);
                end
                if ($urandom_range(99, 0) < 85) begin
                    if (capture_pending)
                        send_report($urandom_range(9, 0) != 0);
                    else if (fault_latched || cur_step >= POSE_COUNT)
                        send_begin();
                    else
                        send_samples(1, cx, spread_x, cy, spread_y);
                    useful++;
                end else begin
                    op = 2'($urandom);
                    if (op == OP_BEGIN ||
                        (op == OP_REPORT && capture_pending) ||
                        (op == OP_SAMPLE && !capture_pending && !fault_latched &&
                         cur_step < POSE_COUNT))
                        useful++;
                    send_item(op, 16'($urandom), 16'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    // The receiver holds off while items keep coming, then both sides run flat out.
    task automatic test_backpressure();
        wait_idle();
        set_config(REG_VARIANCE_LIMIT, LIMIT_RESET);
        set_config(REG_STABLE_TICKS, 1);
        tx_gaps_on = 1'b0;
        rx_hold_left = 80;
        send_begin();
        send_samples(40, 100, 3, 100, 3);
        send_report(1'b1);
        rx_gaps_on = 1'b0;
        for (int p = 1; p < 2; p++)
            run_pose(21, 1'b1);
        send_begin();
        send_samples(30, -2000, 4, 2000, 4);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // Result side: ready with random gaps, or held low for a counted stretch.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_gaps_on && $urandom_range(99, 0) < IDLE_PCT);
            end
        end
    end

    // Each result item is checked field by field against the oldest prediction.
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[6:0];
            if (expected_status.size() == 0) begin
                note_mismatch("result with no item pending", 0, m_tdata);
            end else begin
                want = expected_status.pop_front();
                if (got.step !== want.step)
                    note_mismatch("step", want.step, got.step);
                if (got.capture_request !== want.capture_request)
                    note_mismatch("capture_request", want.capture_request, got.capture_request);
                if (got.done_res !== want.done_res)
                    note_mismatch("done_res", want.done_res, got.done_res);
                if (got.error !== want.error)
                    note_mismatch("error", want.error, got.error);
                if (got.stable !== want.stable)
                    note_mismatch("stable", want.stable, got.stable);
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        rx_hold_left = 0;
        clear_window();
        cur_step = 3'd0;
        capture_pending = 1'b0;
        fault_latched = 1'b0;
        cfg_limit = LIMIT_RESET;
        cfg_ticks = TICKS_RESET;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_register_access();
        test_field_extremes();
        test_capture_flow();
        test_slow_ticks();
        test_random_calibration();
        test_backpressure();
        wait_idle();
        repeat (8) @(posedge aclk);

        if (fail_count == 0)
            $display("[tilt_stillness_calibration_sequencer_unit] OK");
        else
            $display("[tilt_stillness_calibration_sequencer_unit] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tscs_pkg.sv
rtl/tilt_stillness_calibration_sequencer_unit.sv
sim/testbench.sv
